@@ src/tca_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-level chunk allocator package
// Shared request codes, status codes, search constants and helper functions.
// ----------------------------------------------------------------------------
package tca_pkg;

    localparam int GROUP       = 16;
    localparam int GROUP_W     = 4;
    localparam int BLK_IDX_W   = 8;
    localparam int COUNT_W     = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_REINIT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;

    typedef struct packed {
        logic                 done;
        logic                 use_found;
        logic [BLK_IDX_W-1:0] use_idx;
        logic                 open_found;
        logic [BLK_IDX_W-1:0] open_idx;
    } scan_res_t;

    function automatic logic [GROUP_W-1:0] lowest_set(input logic [GROUP-1:0] v);
        logic [GROUP_W-1:0] idx;
        idx = '0;
        for (int i = GROUP - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GROUP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/tca_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module tca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tca_scan.sv @@
// ----------------------------------------------------------------------------
// Block search unit
// Walks the block maps one group of sixteen blocks per cycle and finds the
// lowest in-use block with a free slot or, failing that, the lowest openable free block.
// ----------------------------------------------------------------------------
module tca_scan #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [NUM_BLOCKS-1:0]             in_use,
    input  logic [NUM_BLOCKS-1:0]             has_free,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]   lim,
    output tca_pkg::scan_res_t                res
);
    import tca_pkg::*;

    localparam int NUM_GROUPS = (NUM_BLOCKS + GROUP - 1) / GROUP;
    localparam int PAD        = NUM_GROUPS * GROUP;
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    logic [PAD-1:0]       use_pad;
    logic [PAD-1:0]       free_pad;
    logic [GROUP-1:0]     use_grp;
    logic [GROUP-1:0]     lim_mask;
    logic [GROUP-1:0]     cand_use;
    logic [GROUP-1:0]     cand_open;

    logic                 busy_reg;
    logic                 done_reg;
    logic [GW-1:0]        grp_reg;
    logic                 use_found_reg;
    logic                 open_found_reg;
    logic [BLK_IDX_W-1:0] use_idx_reg;
    logic [BLK_IDX_W-1:0] open_idx_reg;

    assign use_pad  = PAD'(in_use);
    assign free_pad = PAD'(has_free);

    always_comb begin
        use_grp = use_pad[grp_reg*GROUP +: GROUP];
        for (int i = 0; i < GROUP; i++) begin
            lim_mask[i] = (32'({grp_reg, GROUP_W'(i)}) < 32'(lim));
        end
        cand_use  = use_grp & free_pad[grp_reg*GROUP +: GROUP];
        cand_open = ~use_grp & lim_mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            grp_reg        <= '0;
            use_found_reg  <= 1'b0;
            open_found_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg       <= 1'b1;
                grp_reg        <= '0;
                use_found_reg  <= 1'b0;
                open_found_reg <= 1'b0;
            end else if (busy_reg) begin
                if (|cand_use) begin
                    use_found_reg <= 1'b1;
                    use_idx_reg   <= BLK_IDX_W'({grp_reg, lowest_set(cand_use)});
                    busy_reg      <= 1'b0;
                    done_reg      <= 1'b1;
                end else begin
                    if (|cand_open && !open_found_reg) begin
                        open_found_reg <= 1'b1;
                        open_idx_reg   <= BLK_IDX_W'({grp_reg, lowest_set(cand_open)});
                    end
                    if (grp_reg == GW'(NUM_GROUPS - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign res.done       = done_reg;
    assign res.use_found  = use_found_reg;
    assign res.use_idx    = use_idx_reg;
    assign res.open_found = open_found_reg;
    assign res.open_idx   = open_idx_reg;

endmodule

@@ src/two_level_chunk_allocator.sv @@
// ----------------------------------------------------------------------------
// Two-level chunk allocator
// Bitmap allocator of fixed-size chunks grouped in blocks, one result per
// request.
// ----------------------------------------------------------------------------
// The chunk bitmaps live in a RAM with a registered read; in-use
// and has-free flags per block sit in flip-flops. A request is handled one at
// a time. Free, query and an allocate served from the current block pass
// from acceptance with the bitmap read to update and write back, then to the
// result on the output. Reinitialize and requests naming a block not in use
// skip the bitmap read. An allocate that must search walks the block maps
// sixteen blocks per cycle and stops at the first group holding an in-use
// block with a free slot, then reads that block or opens a free one. The
// next request is accepted in the cycle after the result is registered,
// while that result may still wait on the output.
// ----------------------------------------------------------------------------
module two_level_chunk_allocator #(
    parameter int NUM_BLOCKS      = 64,
    parameter int SLOTS_PER_BLOCK = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [6:0]                  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [5:0]                  s_block_index,
    input  logic [4:0]                  s_chunk_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [5:0]                  m_out_block,
    output logic [4:0]                  m_out_chunk,
    output logic [tca_pkg::COUNT_W-1:0] m_free_count
);
    import tca_pkg::*;

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int LIM_W = $clog2(NUM_BLOCKS + 1);
    localparam int SW    = SLOTS_PER_BLOCK;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [1:0] K_BAD     = 2'd0;
    localparam logic [1:0] K_REINIT  = 2'd1;
    localparam logic [1:0] K_OPEN    = 2'd2;
    localparam logic [1:0] K_NOSPACE = 2'd3;

    localparam logic [SW-1:0] ALL_ONES = {SW{1'b1}};

    function automatic logic [LIM_W-1:0] usable(input logic [6:0] tb);
        return (32'(tb) > NUM_BLOCKS) ? LIM_W'(NUM_BLOCKS) : LIM_W'(tb);
    endfunction

    function automatic logic [COUNT_W-1:0] reload(input logic [6:0] tb);
        logic [31:0] n;
        n = 32'(usable(tb)) * 32'(SLOTS_PER_BLOCK);
        return (n > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
    endfunction

    logic [1:0]            state_reg, state_next;
    logic [1:0]            act_reg, act_next;
    logic [4:0]            cn_reg, cn_next;
    logic [BW-1:0]         addr_reg, addr_next;
    logic [1:0]            kind_reg, kind_next;
    logic [6:0]            total_reg;
    logic [BW-1:0]         cur_reg, cur_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [NUM_BLOCKS-1:0] in_use_reg, in_use_next;
    logic [NUM_BLOCKS-1:0] has_free_reg, has_free_next;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            status_reg, status_next;
    logic [5:0]            out_block_reg, out_block_next;
    logic [4:0]            out_chunk_reg, out_chunk_next;
    logic [COUNT_W-1:0]    free_count_reg;

    logic                  ram_we;
    logic [BW-1:0]         ram_waddr;
    logic [SW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [BW-1:0]         ram_raddr;
    logic [SW-1:0]         ram_rdata;

    logic                  scan_start;
    scan_res_t             scan_res;

    logic                  accept;
    logic                  out_free;
    logic                  in_range;
    logic [BW-1:0]         req_blk;
    logic [SW-1:0]         low_oh;
    logic [SW-1:0]         slot_sel;
    logic [SW-1:0]         bm_set;
    logic [SW-1:0]         bm_clr;
    logic [4:0]            low_num;
    logic [COUNT_W-1:0]    count_dec;
    logic [COUNT_W-1:0]    count_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign in_range  = (32'(s_block_index) < NUM_BLOCKS);
    assign req_blk   = BW'(s_block_index);

    assign count_dec = (count_reg == '0) ? '0 : count_reg - 1'b1;
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    always_comb begin
        low_oh  = ~ram_rdata & (ram_rdata + 1'b1);
        bm_set  = ram_rdata | low_oh;
        low_num = '0;
        for (int i = 0; i < SW; i++) begin
            slot_sel[i] = (cn_reg == 5'(i + 1));
            if (low_oh[i]) begin
                low_num = 5'(i + 1);
            end
        end
        bm_clr = ram_rdata & ~slot_sel;
    end

    tca_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_BLOCKS)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tca_scan #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .in_use   (in_use_reg),
        .has_free (has_free_reg),
        .lim      (usable(total_reg)),
        .res      (scan_res)
    );

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        cn_next        = cn_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        count_next     = count_reg;
        in_use_next    = in_use_reg;
        has_free_next  = has_free_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        out_block_next = out_block_reg;
        out_chunk_next = out_chunk_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = bm_set;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;
        scan_start     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next = s_action;
                    cn_next  = s_chunk_number;
                    case (s_action)
                        ACT_ALLOC: begin
                            if (cur_valid_reg && has_free_reg[cur_reg]) begin
                                ram_re     = 1'b1;
                                ram_raddr  = cur_reg;
                                addr_next  = cur_reg;
                                state_next = S_READ;
                            end else begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_FREE, ACT_QUERY: begin
                            if (in_range && in_use_reg[req_blk]) begin
                                ram_re     = 1'b1;
                                ram_raddr  = req_blk;
                                addr_next  = req_blk;
                                state_next = S_READ;
                            end else begin
                                kind_next  = K_BAD;
                                state_next = S_FIN;
                            end
                        end
                        default: begin
                            kind_next  = K_REINIT;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    if (scan_res.use_found) begin
                        ram_re     = 1'b1;
                        ram_raddr  = BW'(scan_res.use_idx);
                        addr_next  = BW'(scan_res.use_idx);
                        state_next = S_READ;
                    end else if (scan_res.open_found) begin
                        addr_next  = BW'(scan_res.open_idx);
                        kind_next  = K_OPEN;
                        state_next = S_FIN;
                    end else begin
                        kind_next  = K_NOSPACE;
                        state_next = S_FIN;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_block_next = '0;
                    out_chunk_next = '0;
                    status_next    = ST_OK;
                    cur_next       = addr_reg;
                    cur_valid_next = 1'b1;
                    if (act_reg == ACT_ALLOC) begin
                        ram_we                  = 1'b1;
                        ram_wdata               = bm_set;
                        has_free_next[addr_reg] = (bm_set != ALL_ONES);
                        count_next              = count_dec;
                        out_block_next          = 6'(addr_reg);
                        out_chunk_next          = low_num;
                    end else if (!(|(ram_rdata & slot_sel))) begin
                        status_next = ST_NOTALLOC;
                    end else if (act_reg == ACT_FREE) begin
                        ram_we                  = 1'b1;
                        ram_wdata               = bm_clr;
                        has_free_next[addr_reg] = 1'b1;
                        count_next              = count_inc;
                        if (bm_clr == '0) begin
                            in_use_next[addr_reg] = 1'b0;
                            cur_next              = '0;
                            cur_valid_next        = 1'b0;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_block_next = '0;
                    out_chunk_next = '0;
                    status_next    = ST_OK;
                    case (kind_reg)
                        K_BAD: begin
                            status_next = ST_NOTALLOC;
                        end
                        K_REINIT: begin
                            cur_next       = '0;
                            cur_valid_next = 1'b0;
                            count_next     = reload(total_reg);
                        end
                        K_OPEN: begin
                            ram_we                  = 1'b1;
                            ram_wdata               = SW'(1);
                            in_use_next[addr_reg]   = 1'b1;
                            has_free_next[addr_reg] = (SW > 1);
                            cur_next                = addr_reg;
                            cur_valid_next          = 1'b1;
                            count_next              = count_dec;
                            out_block_next          = 6'(addr_reg);
                            out_chunk_next          = 5'd1;
                        end
                        default: begin
                            status_next    = ST_NOSPACE;
                            cur_next       = '0;
                            cur_valid_next = 1'b0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            total_reg     <= 7'd64;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            count_reg     <= reload(7'd64);
            in_use_reg    <= '0;
            has_free_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            count_reg     <= count_next;
            in_use_reg    <= in_use_next;
            has_free_reg  <= has_free_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        cn_reg         <= cn_next;
        addr_reg       <= addr_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        out_block_reg  <= out_block_next;
        out_chunk_reg  <= out_chunk_next;
        if (m_valid_next && !(m_valid_reg && !m_ready)) begin
            free_count_reg <= count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_block  = out_block_reg;
    assign m_out_chunk  = out_chunk_reg;
    assign m_free_count = free_count_reg;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Two-level chunk allocator testbench
// Drives allocate, free, query and reinitialize requests with random gaps on
// both sides, rewrites the block limit between phases while the allocator is
// idle, and compares every response field by field against a cycle-free
// model of the bitmap allocator kept inside this bench.
// ----------------------------------------------------------------------------
module testbench;
    import tca_pkg::*;

    localparam int NBLK          = 64;
    localparam int NSLOT         = 16;
    localparam logic [15:0] FULL_MAP = 16'hFFFF;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 85;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_TRIGGER  = 150;

    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg_value;
        logic [1:0] action;
        logic [5:0] blk;
        logic [4:0] chunk;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         blk;
        logic [4:0]         chunk;
        logic [COUNT_W-1:0] count;
    } reply_t;

    typedef struct packed {
        logic [5:0] blk;
        logic [4:0] chunk;
    } handle_t;

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [6:0]          cfg_data       = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [1:0]          s_action       = ACT_ALLOC;
    logic [5:0]          s_block_index  = '0;
    logic [4:0]          s_chunk_number = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [1:0]          m_status;
    logic [5:0]          m_out_block;
    logic [4:0]          m_out_chunk;
    logic [COUNT_W-1:0]  m_free_count;

    request_t pending_requests[$];
    reply_t   awaited_replies[$];
    handle_t  granted_handles[$];

    logic [15:0] slot_map [NBLK];
    bit          blk_used [NBLK];
    bit          blk_full [NBLK];
    logic [5:0]  cur_blk;
    bit          cur_ok;
    int          avail;
    logic [6:0]  total_setting;

    int failures     = 0;
    int replies_seen = 0;
    int hold_left    = 0;
    bit hold_started = 1'b0;
    int cycle_count  = 0;
    int in_calm      = 0;
    int out_calm     = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int settle_left  = SETTLE_CYCLES;

    two_level_chunk_allocator #(
        .NUM_BLOCKS      (NBLK),
        .SLOTS_PER_BLOCK (NSLOT)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_block_index  (s_block_index),
        .s_chunk_number (s_chunk_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_block    (m_out_block),
        .m_out_chunk    (m_out_chunk),
        .m_free_count   (m_free_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int usable_blocks();
        return (total_setting > NBLK) ? NBLK : int'(total_setting);
    endfunction

    function automatic void reload_avail();
        int n;
        n = usable_blocks() * NSLOT;
        avail = (n > int'(COUNT_MAX)) ? int'(COUNT_MAX) : n;
    endfunction

    function automatic void reset_model();
        for (int b = 0; b < NBLK; b++) begin
            slot_map[b] = '0;
            blk_used[b] = 1'b0;
            blk_full[b] = 1'b0;
        end
        cur_blk = '0;
        cur_ok = 1'b0;
        total_setting = 7'd64;
        reload_avail();
    endfunction

    function automatic int lowest_clear(input logic [15:0] map);
        for (int c = 0; c < NSLOT; c++) begin
            if (!map[c]) begin
                return c;
            end
        end
        return NSLOT;
    endfunction

    function automatic void take_slot(input int b, input int c);
        slot_map[b][c] = 1'b1;
        if (avail > 0) begin
            avail--;
        end
        if (slot_map[b] == FULL_MAP) begin
            blk_full[b] = 1'b1;
        end
    endfunction

    function automatic reply_t compute_reply(input logic [1:0] act, input logic [5:0] blk,
                                             input logic [4:0] cn);
        reply_t rep;
        bit     done;
        int     c;
        rep = '0;
        rep.status = ST_OK;
        done = 1'b0;
        if (act == ACT_ALLOC) begin
            if (cur_ok) begin
                c = lowest_clear(slot_map[cur_blk]);
                if (c < NSLOT) begin
                    take_slot(cur_blk, c);
                    rep.blk = cur_blk;
                    rep.chunk = 5'(c + 1);
                    done = 1'b1;
                end
            end
            if (!done) begin
                cur_ok = 1'b0;
                cur_blk = '0;
                for (int b = 0; b < NBLK && !done; b++) begin
                    if (blk_used[b] && !blk_full[b]) begin
                        c = lowest_clear(slot_map[b]);
                        if (c < NSLOT) begin
                            cur_blk = 6'(b);
                            cur_ok = 1'b1;
                            take_slot(b, c);
                            rep.blk = 6'(b);
                            rep.chunk = 5'(c + 1);
                            done = 1'b1;
                        end
                    end
                end
            end
            if (!done) begin
                for (int b = 0; b < usable_blocks() && !done; b++) begin
                    if (!blk_used[b]) begin
                        blk_used[b] = 1'b1;
                        blk_full[b] = 1'b0;
                        slot_map[b] = '0;
                        cur_blk = 6'(b);
                        cur_ok = 1'b1;
                        take_slot(b, 0);
                        rep.blk = 6'(b);
                        rep.chunk = 5'd1;
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                rep.status = ST_NOSPACE;
            end
        end else if (act == ACT_FREE || act == ACT_QUERY) begin
            if (!blk_used[blk]) begin
                rep.status = ST_NOTALLOC;
            end else begin
                cur_blk = blk;
                cur_ok = 1'b1;
                if (cn == 0 || cn > NSLOT || !slot_map[blk][cn - 1]) begin
                    rep.status = ST_NOTALLOC;
                end else if (act == ACT_FREE) begin
                    slot_map[blk][cn - 1] = 1'b0;
                    blk_full[blk] = 1'b0;
                    if (slot_map[blk] == '0) begin
                        blk_used[blk] = 1'b0;
                        cur_blk = '0;
                        cur_ok = 1'b0;
                    end
                    if (avail < int'(COUNT_MAX)) begin
                        avail++;
                    end
                end
            end
        end else begin
            cur_blk = '0;
            cur_ok = 1'b0;
            for (int b = 0; b < NBLK; b++) begin
                blk_full[b] = 1'b0;
            end
            reload_avail();
        end
        rep.count = COUNT_W'(avail);
        return rep;
    endfunction

    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void push_request(input logic [1:0] act, input logic [5:0] blk,
                                         input logic [4:0] cn);
        request_t r;
        r.is_cfg = 1'b0;
        r.cfg_value = '0;
        r.action = act;
        r.blk = blk;
        r.chunk = cn;
        pending_requests.push_back(r);
    endfunction

    function automatic void push_setting(input logic [6:0] value);
        request_t r;
        r.is_cfg = 1'b1;
        r.cfg_value = value;
        r.action = ACT_ALLOC;
        r.blk = '0;
        r.chunk = '0;
        pending_requests.push_back(r);
    endfunction

    function automatic void push_random_request(input int alloc_pct);
        int      pick;
        int      idx;
        handle_t h;
        logic [4:0] cn;
        pick = $urandom_range(0, 99);
        if (pick >= 98) begin
            push_request(ACT_REINIT, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
        end else if (pick >= 90) begin
            cn = ($urandom_range(0, 31) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
            push_request($urandom_range(0, 1) ? ACT_FREE : ACT_QUERY,
                         6'($urandom_range(0, 63)), cn);
        end else if ($urandom_range(0, 99) < alloc_pct || granted_handles.size() == 0) begin
            push_request(ACT_ALLOC, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
        end else begin
            idx = $urandom_range(0, granted_handles.size() - 1);
            h = granted_handles[idx];
            if ($urandom_range(0, 9) < 7) begin
                granted_handles.delete(idx);
                push_request(ACT_FREE, h.blk, h.chunk);
            end else begin
                push_request(ACT_QUERY, h.blk, h.chunk);
            end
        end
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin : request_driver
        logic   sv_n;
        logic   cv_n;
        reply_t rep;
        if (!aresetn) begin
            reset_model();
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            settle_left = SETTLE_CYCLES;
        end else begin
            sv_n = s_valid;
            cv_n = cfg_valid;
            if (s_valid && s_ready) begin
                rep = compute_reply(s_action, s_block_index, s_chunk_number);
                awaited_replies.push_back(rep);
                if (s_action == ACT_ALLOC && rep.status == ST_OK) begin
                    granted_handles.push_back('{blk: rep.blk, chunk: rep.chunk});
                end
                sv_n = 1'b0;
                gap_left = (hold_left > 0) ? 0 : draw_pause(in_calm);
            end
            if (cfg_valid && cfg_ready) begin
                total_setting = cfg_data;
                cv_n = 1'b0;
            end
            if (!sv_n && !cv_n && pending_requests.size() != 0) begin
                if (pending_requests[0].is_cfg) begin
                    if (awaited_replies.size() != 0) begin
                        settle_left = SETTLE_CYCLES;
                    end else if (settle_left > 0) begin
                        settle_left--;
                    end else begin
                        cfg_data <= pending_requests[0].cfg_value;
                        cv_n = 1'b1;
                        void'(pending_requests.pop_front());
                        settle_left = SETTLE_CYCLES;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    s_action <= pending_requests[0].action;
                    s_block_index <= pending_requests[0].blk;
                    s_chunk_number <= pending_requests[0].chunk;
                    sv_n = 1'b1;
                    void'(pending_requests.pop_front());
                end
            end
            s_valid <= sv_n;
            cfg_valid <= cv_n;
        end
    end

    always @(posedge aclk) begin : reply_monitor
        logic   rdy_n;
        reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            rdy_n = m_ready;
            if (m_valid && m_ready) begin
                replies_seen++;
                if (awaited_replies.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected reply: status %0d block %0d chunk %0d count %0d",
                        m_status, m_out_block, m_out_chunk, m_free_count));
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_status !== want.status || m_out_block !== want.blk ||
                        m_out_chunk !== want.chunk || m_free_count !== want.count) begin
                        note_failure($sformatf(
                            {"reply mismatch: expected status %0d block %0d chunk %0d ",
                             "count %0d, got status %0d block %0d chunk %0d count %0d"},
                            want.status, want.blk, want.chunk, want.count,
                            m_status, m_out_block, m_out_chunk, m_free_count));
                    end
                end
                stall_left = draw_pause(out_calm);
                if (stall_left > 0) begin
                    rdy_n = 1'b0;
                end
            end
            if (hold_left > 0) begin
                rdy_n = 1'b0;
            end else if (!rdy_n) begin
                if (stall_left > 0) begin
                    stall_left--;
                end else begin
                    rdy_n = 1'b1;
                end
            end
            m_ready <= rdy_n;
        end
    end

    always @(posedge aclk) begin : reply_holdoff
        if (!aresetn) begin
            hold_left <= 0;
            hold_started <= 1'b0;
        end else if (!hold_started && replies_seen >= HOLD_TRIGGER) begin
            hold_left <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int phase_total [NUM_PHASES];
        int phase_alloc [NUM_PHASES];
        int total;

        phase_total = '{64, 2, 1, 17, 0, 64, 3, 0, 40, 64};
        phase_alloc = '{55, 75, 85, 45, 65, 30, 80, 60, 50, 40};

        // Single-block pool: release, fill, out of space, then a stale full flag.
        push_setting(7'd1);
        push_request(ACT_FREE, 6'd0, 5'd1);
        push_request(ACT_QUERY, 6'd63, 5'd16);
        push_request(ACT_ALLOC, 6'd63, 5'd31);
        push_request(ACT_QUERY, 6'd0, 5'd1);
        push_request(ACT_QUERY, 6'd0, 5'd0);
        push_request(ACT_QUERY, 6'd0, 5'd16);
        push_request(ACT_FREE, 6'd0, 5'd31);
        push_request(ACT_FREE, 6'd0, 5'd1);
        for (int i = 0; i < NSLOT; i++) begin
            push_request(ACT_ALLOC, '0, '0);
        end
        push_request(ACT_ALLOC, '0, '0);
        push_request(ACT_REINIT, 6'd63, 5'd31);
        push_request(ACT_ALLOC, '0, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            total = (phase_total[p] == 0) ? $urandom_range(1, 64) : phase_total[p];
            push_setting(7'(total));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                while (pending_requests.size() >= 4) begin
                    @(posedge aclk);
                end
                push_random_request(phase_alloc[p]);
            end
        end

        while (pending_requests.size() != 0 || s_valid || cfg_valid ||
               awaited_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited_replies.size() != 0) begin
            note_failure($sformatf("%0d replies never arrived", awaited_replies.size()));
        end
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
